// ===== sv/fyuv_pkg.sv =====
// Shared constants and types for the fp16 YUV to RGBA pixel converter.
// No dependencies; every other file in this block imports it.
`timescale 1ns / 1ps

package fyuv_pkg;

	localparam int HALF_W  = 16;
	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int NUM_CH  = 3;

	// channel slots inside the per-channel arrays
	localparam int CH_Y  = 0;
	localparam int CH_CB = 1;
	localparam int CH_CR = 2;

	// register stages from input word to output word
	localparam int PIPE_DEPTH = 5;

	localparam logic [BYTE_W-1:0] ALPHA_BYTE    = 8'hFF;
	localparam logic [BYTE_W-1:0] CHROMA_OFFSET = 8'd128;

	// 16.16 BT.601 full-range coefficients, signed for the signed multiplies
	localparam int COEF_W = 18;
	localparam logic signed [COEF_W-1:0] COEF_CR_R = 18'sd91881;
	localparam logic signed [COEF_W-1:0] COEF_CB_G = 18'sd22554;
	localparam logic signed [COEF_W-1:0] COEF_CR_G = 18'sd46802;
	localparam logic signed [COEF_W-1:0] COEF_CB_B = 18'sd116130;

	// coefficient times chroma stays below 2^24 in magnitude
	localparam int PROD_W = 25;

	typedef enum logic [1:0] {
		HK_NORM,   // finite, 0 <= value < 1.0
		HK_ZERO,   // NaN or negative: byte 0
		HK_FULL    // 1.0 or more, +inf: byte 255
	} half_kind_t;

endpackage

// ===== sv/fyuv_if.sv =====
// Valid/ready channel interfaces for the YUV input word and the RGBA output word.
// Depends on fyuv_pkg for field widths.
`timescale 1ns / 1ps

interface fyuv_in_if
	import fyuv_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] luma_half;
	logic [HALF_W-1:0] cb_half;
	logic [HALF_W-1:0] cr_half;

	modport source (output valid, output luma_half, output cb_half, output cr_half,
		input ready);
	modport sink (input valid, input luma_half, input cb_half, input cr_half,
		output ready);
endinterface

interface fyuv_out_if
	import fyuv_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] rgba_word;

	modport source (output valid, output rgba_word, input ready);
	modport sink (input valid, input rgba_word, output ready);
endinterface

// ===== sv/fp16_yuv_to_rgba_pixel.sv =====
// fp16 YUV to RGBA pixel converter: five register stages; needs fyuv_pkg and fyuv_if.
// Throughput: one word per clock unless an output stall backs up to the input; every stage
// advances when it is empty or the stage after it advances, so an output stall backs up without loss.
// Reset (arst_n low, asynchronous) clears the stage valid bits and holds yuv.ready low.
`timescale 1ns / 1ps

module fp16_yuv_to_rgba_pixel
	import fyuv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	fyuv_in_if.sink      yuv,
	fyuv_out_if.source   rgba
);

	// Stage map
	//   s1: decode half fields, significand * 255, exponent shift amount
	//   s2: align product and add one half (units of 2^-24)
	//   s3: binary32 round-to-nearest folded into a carry, clamp, chroma offset
	//   s4: coefficient multiplies
	//   s5: channel sums, floor shift, clamp, pack

	localparam int SIG_W   = 11;
	localparam int PRD_W   = SIG_W + BYTE_W;   // sig * 255
	localparam int SHF_W   = 4;                // shift <= 13
	localparam int SUM_W   = 32;               // value*255 + 0.5 below 2^32 units
	localparam int FRAC_W  = 24;
	localparam int SH_W    = PROD_W - 16;      // result of the >>> 16
	localparam int CHAN_W  = SH_W + 1;         // y +/- shifted term

	// ---------------- handshake ----------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5 = !valid_s5 || rgba.ready;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	// no word is taken while reset is held
	assign yuv.ready  = adv1 && arst_n;
	assign rgba.valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= yuv.valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	// ---------------- stage 1: half decode ----------------
	logic [HALF_W-1:0] half_in [NUM_CH];
	logic [PRD_W-1:0]  prod_c  [NUM_CH];
	logic [SHF_W-1:0]  shift_c [NUM_CH];
	half_kind_t        kind_c  [NUM_CH];

	assign half_in[CH_Y]  = yuv.luma_half;
	assign half_in[CH_CB] = yuv.cb_half;
	assign half_in[CH_CR] = yuv.cr_half;

	always_comb begin
		logic [4:0]       expf;
		logic [9:0]       mant;
		logic [SIG_W-1:0] sig;
		for (int c = 0; c < NUM_CH; c++) begin
			expf = half_in[c][14:10];
			mant = half_in[c][9:0];
			if ((expf == 5'h1F && mant != 10'd0) || half_in[c][15])
				kind_c[c] = HK_ZERO;
			else if (expf >= 5'd15)
				kind_c[c] = HK_FULL;
			else
				kind_c[c] = HK_NORM;
			// subnormals carry no hidden bit and the same scale as exponent 1
			sig        = (expf == 5'd0) ? {1'b0, mant} : {1'b1, mant};
			shift_c[c] = (expf == 5'd0) ? 4'd0 : SHF_W'(expf - 5'd1);
			// x*255 as x*256 - x
			prod_c[c]  = {sig, {BYTE_W{1'b0}}} - PRD_W'(sig);
		end
	end

	logic [PRD_W-1:0] prod_s1  [NUM_CH];
	logic [SHF_W-1:0] shift_s1 [NUM_CH];
	half_kind_t       kind_s1  [NUM_CH];

	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_s1  <= prod_c;
			shift_s1 <= shift_c;
			kind_s1  <= kind_c;
		end
	end

	// ---------------- stage 2: align and add one half ----------------
	logic [SUM_W-1:0] sum_c [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++)
			sum_c[c] = (SUM_W'(prod_s1[c]) << shift_s1[c]) + (SUM_W'(1) << (FRAC_W - 1));
	end

	logic [SUM_W-1:0] sum_s2  [NUM_CH];
	half_kind_t       kind_s2 [NUM_CH];

	always_ff @(posedge clk) begin
		if (adv2) begin
			sum_s2  <= sum_c;
			kind_s2 <= kind_s1;
		end
	end

	// ---------------- stage 3: round, clamp, chroma offset ----------------
	// Rounding the sum to 24 significant bits only changes the integer part
	// when it carries into bit 24: the leading one sits at bit p >= 24 and
	// bits 23 down to p-24 are all set (the round bit and everything above).
	logic [BYTE_W-1:0] byte_c [NUM_CH];

	always_comb begin
		logic           carry;
		logic [BYTE_W:0] rounded;
		for (int c = 0; c < NUM_CH; c++) begin
			carry = 1'b0;
			for (int p = FRAC_W; p < SUM_W; p++) begin
				if (sum_s2[c][p])
					carry = ((sum_s2[c][FRAC_W-1:0]
						| FRAC_W'((25'd1 << (p - FRAC_W)) - 25'd1)) == {FRAC_W{1'b1}});
			end
			rounded = {1'b0, sum_s2[c][SUM_W-1:FRAC_W]} + (BYTE_W+1)'(carry);
			case (kind_s2[c])
				HK_ZERO: byte_c[c] = '0;
				HK_FULL: byte_c[c] = '1;
				default: byte_c[c] = rounded[BYTE_W] ? '1 : rounded[BYTE_W-1:0];
			endcase
		end
	end

	logic        [BYTE_W-1:0] y_s3;
	logic signed [BYTE_W-1:0] u_s3, v_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			y_s3 <= byte_c[CH_Y];
			// byte - 128 always fits in a signed byte
			u_s3 <= $signed(byte_c[CH_CB] - CHROMA_OFFSET);
			v_s3 <= $signed(byte_c[CH_CR] - CHROMA_OFFSET);
		end
	end

	// ---------------- stage 4: coefficient multiplies ----------------
	logic signed [COEF_W+BYTE_W-1:0] pr_c, pgu_c, pgv_c, pb_c;

	assign pr_c  = COEF_CR_R * v_s3;
	assign pgu_c = COEF_CB_G * u_s3;
	assign pgv_c = COEF_CR_G * v_s3;
	assign pb_c  = COEF_CB_B * u_s3;

	logic        [BYTE_W-1:0] y_s4;
	logic signed [PROD_W-1:0] pr_s4, pgu_s4, pgv_s4, pb_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			y_s4   <= y_s3;
			pr_s4  <= $signed(pr_c[PROD_W-1:0]);
			pgu_s4 <= $signed(pgu_c[PROD_W-1:0]);
			pgv_s4 <= $signed(pgv_c[PROD_W-1:0]);
			pb_s4  <= $signed(pb_c[PROD_W-1:0]);
		end
	end

	// ---------------- stage 5: sums, floor shift, clamp, pack ----------------
	function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [CHAN_W-1:0] x);
		if (x < 0)
			return '0;
		else if (x > CHAN_W'(255))
			return '1;
		else
			return x[BYTE_W-1:0];
	endfunction

	logic signed [PROD_W-1:0] pg_sum;
	logic signed [SH_W-1:0]   sh_r, sh_g, sh_b;
	logic signed [CHAN_W-1:0] y_ext, r_c, g_c, b_c;

	assign pg_sum = pgu_s4 + pgv_s4;
	// top bits of a two's complement word: floor division by 2^16
	assign sh_r   = $signed(pr_s4[PROD_W-1:16]);
	assign sh_g   = $signed(pg_sum[PROD_W-1:16]);
	assign sh_b   = $signed(pb_s4[PROD_W-1:16]);
	assign y_ext  = $signed({{(CHAN_W-BYTE_W){1'b0}}, y_s4});
	assign r_c    = y_ext + CHAN_W'(sh_r);
	assign g_c    = y_ext - CHAN_W'(sh_g);
	assign b_c    = y_ext + CHAN_W'(sh_b);

	logic [WORD_W-1:0] word_s5;

	always_ff @(posedge clk) begin
		if (adv5)
			word_s5 <= {ALPHA_BYTE, clamp_byte(b_c), clamp_byte(g_c), clamp_byte(r_c)};
	end

	assign rgba.rgba_word = word_s5;

endmodule

// ===== sv/fyuv_checker.sv =====
// Port-level assertions for fp16_yuv_to_rgba_pixel, attached by bind.
// Depends on fyuv_pkg for the pipeline depth and alpha byte.
`timescale 1ns / 1ps

module fyuv_checker
	import fyuv_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] out_word
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic             in_acc, out_acc;
	logic [CNT_W-1:0] inflight_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (in_acc && !out_acc)
			inflight_q <= inflight_q + CNT_W'(1);
		else if (out_acc && !in_acc)
			inflight_q <= inflight_q - CNT_W'(1);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word dropped or changed while stalled");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word[WORD_W-1:WORD_W-BYTE_W] == ALPHA_BYTE)
		else $error("alpha byte not opaque");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("output word with no input word behind it");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(PIPE_DEPTH))
		else $error("more words in flight than pipeline stages");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output is free");

endmodule

bind fp16_yuv_to_rgba_pixel fyuv_checker u_fyuv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (yuv.valid),
	.in_ready  (yuv.ready),
	.out_valid (rgba.valid),
	.out_ready (rgba.ready),
	.out_word  (rgba.rgba_word)
);

// ===== tb/tb_fp16_yuv_to_rgba_pixel.sv =====
// Testbench for fp16_yuv_to_rgba_pixel: directed and random YUV words, a local
// BT.601 predictor, and an in-order check of every RGBA word.
// Depends on fyuv_pkg and the fyuv_in_if / fyuv_out_if interfaces.
`timescale 1ns / 1ps

module tb_fp16_yuv_to_rgba_pixel;
	import fyuv_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 150;

	// 16.16 conversion coefficients and chroma bias
	localparam int K_CR_R  = 91881;
	localparam int K_CB_G  = 22554;
	localparam int K_CR_G  = 46802;
	localparam int K_CB_B  = 116130;
	localparam int C_BIAS  = 128;
	localparam logic [7:0] OPAQUE = 8'hFF;

	logic clk;
	logic arst_n;

	fyuv_in_if  yuv_ch ();
	fyuv_out_if rgba_ch ();

	fp16_yuv_to_rgba_pixel i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.yuv    (yuv_ch),
		.rgba   (rgba_ch)
	);

	// Expected RGBA words in arrival order, and the checks against them.
	class pixel_scoreboard;
		logic [31:0] rgba_queue[$];
		int          fails;

		function new();
			fails = 0;
		endfunction

		// binary16 -> byte: floor(value*255 + 0.5) with the sum rounded to a
		// 24-bit significand, nearest-even; NaN and negatives give 0
		function int half_to_byte(logic [15:0] h);
			logic [4:0]  expf;
			logic [9:0]  mant;
			logic [63:0] sig, sum, unit, rem, half;
			int unsigned shift, len, drop;
			half_kind_t  kind;
			expf = h[14:10];
			mant = h[9:0];
			if (expf == 5'h1F && mant != 0)
				kind = HK_ZERO;
			else if (h[15])
				kind = HK_ZERO;
			else if (expf >= 5'd15)
				kind = HK_FULL;
			else
				kind = HK_NORM;
			if (kind == HK_ZERO)
				return 0;
			if (kind == HK_FULL)
				return 255;
			if (expf == 0) begin
				sig = {54'd0, mant};
				shift = 0;
			end else begin
				sig = {53'd0, 1'b1, mant};
				shift = expf - 1;
			end
			// units of 2^-24
			sum = ((sig * 64'd255) << shift) + (64'd1 << 23);
			len = 0;
			while (len < 63 && (sum >> len) != 0)
				len++;
			if (len > 24) begin
				drop = len - 24;
				unit = 64'd1 << drop;
				half = unit >> 1;
				rem = sum & (unit - 1);
				sum = sum - rem;
				if (rem > half || (rem == half && sum[drop]))
					sum = sum + unit;
			end
			sum = sum >> 24;
			if (sum > 255)
				sum = 255;
			return int'(sum);
		endfunction

		function logic [7:0] clamp_byte(int x);
			if (x < 0)
				return 8'd0;
			if (x > 255)
				return 8'd255;
			return x[7:0];
		endfunction

		// accepted input word: predict its RGBA word
		function void note_pixel(logic [15:0] luma, logic [15:0] cb, logic [15:0] cr);
			int y, u, v;
			logic [7:0] r, g, b;
			y = half_to_byte(luma);
			u = half_to_byte(cb) - C_BIAS;
			v = half_to_byte(cr) - C_BIAS;
			r = clamp_byte(y + ((K_CR_R * v) >>> 16));
			g = clamp_byte(y - ((K_CB_G * u + K_CR_G * v) >>> 16));
			b = clamp_byte(y + ((K_CB_B * u) >>> 16));
			rgba_queue.push_back({OPAQUE, b, g, r});
		endfunction

		function void check_word(logic [31:0] got);
			logic [31:0] want;
			if (rgba_queue.size() == 0) begin
				$display("%0t: unexpected rgba_word, expected none, actual %08h", $time, got);
				fails++;
				return;
			end
			want = rgba_queue.pop_front();
			if (got !== want) begin
				$display("%0t: rgba_word mismatch, expected %08h, actual %08h",
					$time, want, got);
				fails++;
			end
		endfunction

		function int pending();
			return rgba_queue.size();
		endfunction
	endclass

	pixel_scoreboard rgba_sb;

	// idling controls, percent chance of a burst before each word / cycle
	int src_stall_pct;
	int sink_stall_pct;
	bit hold_pending;
	int unsigned cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// output side: random ready bursts, one long hold-off on request
	initial begin
		rgba_ch.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				rgba_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 99) < sink_stall_pct) begin
				rgba_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				rgba_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rgba_ch.valid && rgba_ch.ready)
			rgba_sb.check_word(rgba_ch.rgba_word);
	end

	// offer one word, optionally after an idle burst; returns at the accepting edge
	task automatic send_pixel(logic [15:0] luma, logic [15:0] cb, logic [15:0] cr);
		if ($urandom_range(0, 99) < src_stall_pct) begin
			yuv_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		yuv_ch.valid     <= 1'b1;
		yuv_ch.luma_half <= luma;
		yuv_ch.cb_half   <= cb;
		yuv_ch.cr_half   <= cr;
		do
			@(posedge clk);
		while (!yuv_ch.ready);
		rgba_sb.note_pixel(luma, cb, cr);
	endtask

	task automatic drain_pixels();
		yuv_ch.valid <= 1'b0;
		while (rgba_sb.pending() != 0)
			@(posedge clk);
	endtask

	// mostly in-range samples, some near 1.0, some raw patterns and specials
	function automatic logic [15:0] pick_half();
		logic [15:0] specials[8] = '{16'h0000, 16'h8000, 16'h3C00, 16'h7C00,
			16'hFC00, 16'h7E00, 16'h03FF, 16'h3BFF};
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return 16'($urandom_range(0, 16'h3BFF));
		if (sel < 8)
			return 16'($urandom_range(16'h3800, 16'h3C00));
		if (sel == 8)
			return 16'($urandom_range(0, 16'hFFFF));
		return specials[$urandom_range(0, 7)];
	endfunction

	task automatic send_random(int count);
		repeat (count)
			send_pixel(pick_half(), pick_half(), pick_half());
	endtask

	initial begin
		rgba_sb = new();
		cycle_cnt = 0;
		hold_pending = 1'b0;
		src_stall_pct = 20;
		sink_stall_pct = 20;
		yuv_ch.valid     <= 1'b0;
		yuv_ch.luma_half <= '0;
		yuv_ch.cb_half   <= '0;
		yuv_ch.cr_half   <= '0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		@(posedge clk);

		// neutral gray scale and saturated chroma corners
		send_pixel(16'h0000, 16'h3800, 16'h3800);
		send_pixel(16'h3C00, 16'h3800, 16'h3800);
		send_pixel(16'h3C00, 16'h0000, 16'h0000);
		send_pixel(16'h0000, 16'h3C00, 16'h3C00);
		send_pixel(16'h3C00, 16'h3C00, 16'h0000);
		send_pixel(16'h0000, 16'h0000, 16'h3C00);
		send_pixel(16'h3800, 16'h3400, 16'h3A00);
		send_pixel(16'h2E00, 16'h3B00, 16'h3000);
		// infinities, NaNs, negative zero and other negative values
		send_pixel(16'h7C00, 16'h7C00, 16'h7C00);
		send_pixel(16'hFC00, 16'hFC00, 16'hFC00);
		send_pixel(16'h7E00, 16'h7C01, 16'hFFFF);
		send_pixel(16'h8000, 16'h8000, 16'h8000);
		send_pixel(16'hBC00, 16'h3C00, 16'hB800);
		// subnormals, smallest normal, edges around 1.0 and max finite
		send_pixel(16'h0001, 16'h0001, 16'h0001);
		send_pixel(16'h03FF, 16'h03FF, 16'h03FF);
		send_pixel(16'h0400, 16'h0400, 16'h0400);
		send_pixel(16'h1C04, 16'h1C04, 16'h1C04);
		send_pixel(16'h3BFF, 16'h3BFF, 16'h3BFF);
		send_pixel(16'h3C01, 16'h3C01, 16'h3C01);
		send_pixel(16'h7BFF, 16'h7BFF, 16'h7BFF);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		drain_pixels();

		send_random(300);

		// long output hold-off while input keeps offering: pipe fills, ready drops
		src_stall_pct = 0;
		hold_pending = 1'b1;
		send_random(100);
		drain_pixels();

		src_stall_pct = 10;
		sink_stall_pct = 50;
		send_random(150);
		src_stall_pct = 50;
		sink_stall_pct = 5;
		send_random(150);

		// full rate, no idling on either side
		src_stall_pct = 0;
		sink_stall_pct = 0;
		send_random(200);
		drain_pixels();
		repeat (PIPE_DEPTH * 4) @(posedge clk);

		if (rgba_sb.fails == 0 && rgba_sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
